// ===== design/wsot_pkg.sv =====
package wsot_pkg;

   localparam int DEF_OWNER_COUNT       = 8;
   localparam int DEF_WINDOWS_PER_OWNER = 8;
   localparam int MAX_CAPACITY          = 64;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 3;
   localparam int TASK_W   = 6;
   localparam int COUNT_W  = 7;

   // List depth and id space: owners times windows, never above 64.
   function automatic int cap_of(input int owners, input int windows);
      int raw;
      raw = owners * windows;
      return (raw < MAX_CAPACITY) ? raw : MAX_CAPACITY;
   endfunction

   localparam int DEF_CAPACITY = cap_of(DEF_OWNER_COUNT, DEF_WINDOWS_PER_OWNER);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQUEUE      = 3'd0,
      ACT_REMOVE       = 3'd1,
      ACT_REMOVE_OWNER = 3'd2,
      ACT_MOVE_TOP     = 3'd3,
      ACT_ALLOCATE     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_MISS    = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_PRESENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_APPLY,
      ST_PURGE,
      ST_SCAN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    owner_id;
      logic [KEY_W-1:0]    window_num;
      logic [TASK_W-1:0]   task_in;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [TASK_W-1:0]   task_out;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  owner_id;
      logic [KEY_W-1:0]  window_num;
      logic [TASK_W-1:0] task_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             shift;
      logic             load;
      logic [KEY_W-1:0] key_owner;
      logic [KEY_W-1:0] key_window;
      entry_type        data;
   } cell_ctrl_type;

   typedef struct packed {
      logic              free_en;
      logic [TASK_W-1:0] free_id;
      logic              fresh_take;
      logic              scan_clear;
      logic              scan_step;
      logic              scan_take;
   } id_cmd_type;

   typedef struct packed {
      logic              fresh_avail;
      logic [TASK_W-1:0] fresh_id;
      logic              scan_end;
      logic              scan_hit;
      logic [TASK_W-1:0] scan_id;
   } id_stat_type;

endpackage

// ===== design/wsot_cell.sv =====
module wsot_cell
   import wsot_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int CELL_INDEX = 0,
   localparam int LEN_W     = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [LEN_W-1:0]    pos,
   input  logic [LEN_W-1:0]    load_at,
   input  logic [LEN_W-1:0]    length,
   input  entry_type           next_entry,
   output entry_type           entry,
   output logic                key_hit
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      load_here;
   logic      shift_here;

   always_comb begin
      occupied   = LEN_W'(CELL_INDEX) < length;
      load_here  = ctrl.load && (LEN_W'(CELL_INDEX) == load_at);
      shift_here = ctrl.shift && (LEN_W'(CELL_INDEX) >= pos);
      // load wins: move-to-top drops the tail cell's shifted value
      if (load_here) begin
         entry_in = ctrl.data;
      end else if (shift_here) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
      key_hit = occupied && (entry_ff.owner_id == ctrl.key_owner)
                && (entry_ff.window_num == ctrl.key_window);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== design/wsot_id_alloc.sv =====
module wsot_id_alloc
   import wsot_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int IDX_W   = $clog2(CAPACITY),
   localparam int LEN_W   = $clog2(CAPACITY + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  id_cmd_type  cmd,
   output id_stat_type stat
);

   logic [CAPACITY-1:0] map_ff;
   logic [CAPACITY-1:0] map_in;
   logic [LEN_W-1:0]    hw_ff;
   logic [LEN_W-1:0]    hw_in;
   logic [LEN_W-1:0]    scan_ff;
   logic [LEN_W-1:0]    scan_in;
   logic                free_ok;

   always_comb begin
      map_in  = map_ff;
      hw_in   = hw_ff;
      scan_in = scan_ff;
      free_ok = {1'b0, cmd.free_id} < COUNT_W'(CAPACITY);
      // ids outside the id space are dropped
      if (cmd.free_en && free_ok) begin
         map_in[cmd.free_id[IDX_W-1:0]] = 1'b1;
      end
      if (cmd.fresh_take) begin
         map_in[hw_ff[IDX_W-1:0]] = 1'b0;
         hw_in = hw_ff + 1'b1;
      end
      if (cmd.scan_take) begin
         map_in[scan_ff[IDX_W-1:0]] = 1'b0;
      end
      if (cmd.scan_clear) begin
         scan_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end

      stat.fresh_avail = hw_ff < LEN_W'(CAPACITY);
      stat.fresh_id    = TASK_W'(hw_ff);
      stat.scan_end    = scan_ff >= LEN_W'(CAPACITY);
      stat.scan_hit    = !stat.scan_end && map_ff[scan_ff[IDX_W-1:0]];
      stat.scan_id     = TASK_W'(scan_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff  <= '0;
         hw_ff   <= '0;
         scan_ff <= '0;
      end else begin
         map_ff  <= map_in;
         hw_ff   <= hw_in;
         scan_ff <= scan_in;
      end
   end

endmodule

// ===== design/window_stack_order_table.sv =====
// Flow: an accepted transaction passes through the find, apply and reply states; the response
// is loaded once the output register is free or being drained. Remove-all walks the list one
// cell per cycle, and allocation from the free map walks ids one per cycle, before the reply.
// Throughput: one transaction at a time; the next is taken once the response is loaded.
// Reset (synchronous, active high) empties the list, zeroes the id high-water mark and
// marks every id in use; the cell contents are not cleared.
module window_stack_order_table
   import wsot_pkg::*;
#(
   parameter int OWNER_COUNT       = DEF_OWNER_COUNT,
   parameter int WINDOWS_PER_OWNER = DEF_WINDOWS_PER_OWNER
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CAPACITY = cap_of(OWNER_COUNT, WINDOWS_PER_OWNER);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              found_ff, found_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   entry_type         hit_ff, hit_in;
   status_type        status_ff, status_in;
   logic [TASK_W-1:0] tout_ff, tout_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type       cell_ctrl;
   logic [LEN_W-1:0]    load_at;
   logic [CAPACITY-1:0] key_hit;
   entry_type           cell_ent [CAPACITY];
   entry_type           purge_ent;
   logic [LEN_W-1:0]    find_pos;
   logic [ENTRY_W-1:0]  find_vec;
   id_cmd_type          id_cmd;
   id_stat_type         id_stat;

   // Row of cells: cell 0 holds the oldest entry, cell length-1 the top.
   // A shift pulls every cell at or above pos from its upper neighbor,
   // which closes the gap left by a removed entry.
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_type nbr;
      if (gi == CAPACITY - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_ent[gi+1];
      end
      wsot_cell #(
         .CAPACITY   (CAPACITY),
         .CELL_INDEX (gi)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .pos        (pos_ff),
         .load_at    (load_at),
         .length     (len_ff),
         .next_entry (nbr),
         .entry      (cell_ent[gi]),
         .key_hit    (key_hit[gi])
      );
   end

   wsot_id_alloc #(
      .CAPACITY (CAPACITY)
   ) u_id_alloc (
      .clock (clock),
      .reset (reset),
      .cmd   (id_cmd),
      .stat  (id_stat)
   );

   // Keys are unique in the list, so at most one cell hits: OR the hit
   // cell's index and contents together.
   always_comb begin
      find_pos = '0;
      find_vec = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (key_hit[i]) begin
            find_pos = find_pos | LEN_W'(i);
            find_vec = find_vec | cell_ent[i];
         end
      end
   end

   // Remove-all walks one cell per cycle; pos stays below length here.
   assign purge_ent = cell_ent[pos_ff[IDX_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      len_in       = len_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      tout_in      = tout_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);

      cell_ctrl            = '0;
      cell_ctrl.key_owner  = req_ff.owner_id;
      cell_ctrl.key_window = req_ff.window_num;
      load_at              = len_ff;
      id_cmd               = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = STAT_OK;
               tout_in   = '0;
               state_in  = ST_FIND;
            end
         end

         // Compare every cell's key at once; hold the result.
         ST_FIND: begin
            found_in = |key_hit;
            pos_in   = find_pos;
            hit_in   = entry_type'(find_vec);
            state_in = ST_APPLY;
         end

         ST_APPLY: begin
            state_in = ST_REPLY;
            case (req_ff.action)
               ACT_ENQUEUE: begin
                  if (found_ff) begin
                     status_in = STAT_PRESENT;
                  end else if (len_ff >= LEN_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     // append at the top
                     cell_ctrl.load            = 1'b1;
                     cell_ctrl.data.owner_id   = req_ff.owner_id;
                     cell_ctrl.data.window_num = req_ff.window_num;
                     cell_ctrl.data.task_id    = req_ff.task_in;
                     len_in                    = len_ff + 1'b1;
                  end
               end
               ACT_REMOVE: begin
                  if (!found_ff) begin
                     status_in = STAT_MISS;
                  end else begin
                     tout_in         = hit_ff.task_id;
                     id_cmd.free_en  = 1'b1;
                     id_cmd.free_id  = hit_ff.task_id;
                     cell_ctrl.shift = 1'b1;
                     len_in          = len_ff - 1'b1;
                  end
               end
               ACT_REMOVE_OWNER: begin
                  pos_in   = '0;
                  state_in = ST_PURGE;
               end
               ACT_MOVE_TOP: begin
                  if (!found_ff) begin
                     status_in = STAT_MISS;
                  end else begin
                     // close the gap and drop the entry back on top; id stays in use
                     cell_ctrl.shift = 1'b1;
                     cell_ctrl.load  = 1'b1;
                     cell_ctrl.data  = hit_ff;
                     load_at         = len_ff - 1'b1;
                  end
               end
               ACT_ALLOCATE: begin
                  if (id_stat.fresh_avail) begin
                     tout_in           = id_stat.fresh_id;
                     id_cmd.fresh_take = 1'b1;
                  end else begin
                     id_cmd.scan_clear = 1'b1;
                     state_in          = ST_SCAN;
                  end
               end
               default: begin
                  // unused action codes: no change
               end
            endcase
         end

         // Remove every entry of the owner: at a hit, free its id and shift the
         // rest down without advancing; otherwise advance.
         ST_PURGE: begin
            if (pos_ff >= len_ff) begin
               state_in = ST_REPLY;
            end else if (purge_ent.owner_id == req_ff.owner_id) begin
               cell_ctrl.shift = 1'b1;
               len_in          = len_ff - 1'b1;
               id_cmd.free_en  = 1'b1;
               id_cmd.free_id  = purge_ent.task_id;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         // Fresh ids are gone: take the lowest id marked free.
         ST_SCAN: begin
            if (id_stat.scan_end) begin
               status_in = STAT_MISS;
               state_in  = ST_REPLY;
            end else if (id_stat.scan_hit) begin
               tout_in          = id_stat.scan_id;
               id_cmd.scan_take = 1'b1;
               state_in         = ST_REPLY;
            end else begin
               id_cmd.scan_step = 1'b1;
            end
         end

         // Load the output register once it is free or being drained.
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status_ff;
               rsp_in.task_out    = tout_ff;
               rsp_in.entry_count = COUNT_W'(len_ff);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      tout_ff   <= tout_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/wsot_checker.sv =====
module wsot_checker
   import wsot_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one transaction in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // failed transactions never return an id
   a_tout_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.task_out == '0))
      else $error("nonzero task id on a failed transaction");

   // a duplicate key or a full list means the list holds entries
   a_nonempty_on_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STAT_PRESENT || rsp_data.status == STAT_FULL))
      |-> (rsp_data.entry_count != '0))
      else $error("reject reported on an empty list");

   // no response directly out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

endmodule

bind window_stack_order_table wsot_checker u_wsot_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/window_stack_order_table_tb.sv =====
`timescale 1ns / 1ps

module window_stack_order_table_tb;
   import wsot_pkg::*;

   localparam int TABLE_CAP      = DEF_CAPACITY;
   localparam int NO_SLOT        = -1;
   localparam int RANDOM_ACTIONS = 450;
   localparam int IDLE_PERCENT   = 11;
   localparam int QUEUE_AHEAD    = 2;
   localparam int HOLD_AT        = 220;
   localparam int HOLD_CYCLES    = 90;
   localparam int PAUSE_AT       = 330;
   localparam int DRAIN_CYCLES   = 80;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int KEY_MAX        = (1 << KEY_W) - 1;
   localparam int TASK_MAX       = (1 << TASK_W) - 1;

   // Codes 5..7 are outside the action set; the block must ignore them.
   localparam logic [ACTION_W-1:0] ACT_RESERVED_FIRST = 3'd5;
   localparam int                  RESERVED_SPAN      = 2;

   // Stimulus mixes, rotated through the random part.
   typedef enum int {
      MIX_GROW,
      MIX_CHURN,
      MIX_DRAIN,
      MIX_ALLOC
   } mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Transactions waiting for the driver, and replies waiting for the monitor.
   req_type queued_actions[$];
   rsp_type expected_replies[$];

   // Shadow copy of the window stack and the task id allocator.
   entry_type shadow_entries[TABLE_CAP];
   int        shadow_length  = 0;
   bit        shadow_id_free[TABLE_CAP];
   int        shadow_id_mark = 0;

   int issued_count   = 0;
   int accepted_count = 0;
   int answered_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   bit calm_stretch   = 1'b0;

   window_stack_order_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Window stack predictor
   // ---------------------------------------------------------------------

   // Return the stack position of a key, oldest first, or NO_SLOT.
   function automatic int find_slot(input logic [KEY_W-1:0] owner,
                                    input logic [KEY_W-1:0] window);
      int i;
      for (i = 0; i < shadow_length; i++) begin
         if (shadow_entries[i].owner_id == owner && shadow_entries[i].window_num == window)
            return i;
      end
      return NO_SLOT;
   endfunction

   // Drop one entry and pull everything above it down by one.
   function automatic void close_slot(input int slot);
      int i;
      for (i = slot; i + 1 < shadow_length; i++)
         shadow_entries[i] = shadow_entries[i + 1];
      shadow_length--;
   endfunction

   // Ids outside the id space leave the free map alone.
   function automatic void release_id(input logic [TASK_W-1:0] id);
      if (id < TABLE_CAP)
         shadow_id_free[id] = 1'b1;
   endfunction

   // Apply one accepted transaction to the shadow state and return its reply.
   function automatic rsp_type predict_action(input req_type r);
      rsp_type   reply;
      entry_type lifted;
      int        slot;
      int        i;
      reply.status   = STAT_OK;
      reply.task_out = '0;
      case (r.action)
         ACT_ENQUEUE: begin
            // A present key wins over a full stack.
            if (find_slot(r.owner_id, r.window_num) != NO_SLOT) begin
               reply.status = STAT_PRESENT;
            end else if (shadow_length >= TABLE_CAP) begin
               reply.status = STAT_FULL;
            end else begin
               shadow_entries[shadow_length] = '{owner_id: r.owner_id,
                                                 window_num: r.window_num,
                                                 task_id: r.task_in};
               shadow_length++;
            end
         end
         ACT_REMOVE: begin
            slot = find_slot(r.owner_id, r.window_num);
            if (slot == NO_SLOT) begin
               reply.status = STAT_MISS;
            end else begin
               reply.task_out = shadow_entries[slot].task_id;
               release_id(shadow_entries[slot].task_id);
               close_slot(slot);
            end
         end
         ACT_REMOVE_OWNER: begin
            // Always ok, even when nothing of this owner is on the stack.
            i = 0;
            while (i < shadow_length) begin
               if (shadow_entries[i].owner_id == r.owner_id) begin
                  release_id(shadow_entries[i].task_id);
                  close_slot(i);
               end else begin
                  i++;
               end
            end
         end
         ACT_MOVE_TOP: begin
            // The entry keeps its id; a key already on top changes nothing.
            slot = find_slot(r.owner_id, r.window_num);
            if (slot == NO_SLOT) begin
               reply.status = STAT_MISS;
            end else begin
               lifted = shadow_entries[slot];
               close_slot(slot);
               shadow_entries[shadow_length] = lifted;
               shadow_length++;
            end
         end
         ACT_ALLOCATE: begin
            // Fresh ids first, then the lowest freed one.
            if (shadow_id_mark < TABLE_CAP) begin
               reply.task_out = TASK_W'(shadow_id_mark);
               shadow_id_free[shadow_id_mark] = 1'b0;
               shadow_id_mark++;
            end else begin
               reply.status = STAT_MISS;
               for (i = 0; i < TABLE_CAP && reply.status == STAT_MISS; i++) begin
                  if (shadow_id_free[i]) begin
                     shadow_id_free[i] = 1'b0;
                     reply.task_out    = TASK_W'(i);
                     reply.status      = STAT_OK;
                  end
               end
            end
         end
         default: ;
      endcase
      reply.entry_count = COUNT_W'(shadow_length);
      return reply;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_request(input logic [ACTION_W-1:0] act,
                                            input logic [KEY_W-1:0]    owner,
                                            input logic [KEY_W-1:0]    window,
                                            input logic [TASK_W-1:0]   task_id);
      req_type r;
      r.action     = act;
      r.owner_id   = owner;
      r.window_num = window;
      r.task_in    = task_id;
      return r;
   endfunction

   // Mostly aim at a key that is on the stack now, so lookups hit.
   function automatic void pick_key(output logic [KEY_W-1:0] owner,
                                    output logic [KEY_W-1:0] window);
      int slot;
      if (shadow_length > 0 && $urandom_range(0, 99) < 70) begin
         slot   = $urandom_range(0, shadow_length - 1);
         owner  = shadow_entries[slot].owner_id;
         window = shadow_entries[slot].window_num;
      end else begin
         owner  = KEY_W'($urandom_range(0, KEY_MAX));
         window = KEY_W'($urandom_range(0, KEY_MAX));
      end
   endfunction

   function automatic req_type random_action(input mix_type mix);
      logic [ACTION_W-1:0] act;
      logic [KEY_W-1:0]    owner;
      logic [KEY_W-1:0]    window;
      int                  roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:
            act = (roll < 65) ? ACT_ENQUEUE : (roll < 75) ? ACT_REMOVE :
                  (roll < 80) ? ACT_REMOVE_OWNER : (roll < 90) ? ACT_MOVE_TOP : ACT_ALLOCATE;
         MIX_CHURN:
            act = (roll < 25) ? ACT_ENQUEUE : (roll < 45) ? ACT_REMOVE :
                  (roll < 57) ? ACT_REMOVE_OWNER : (roll < 75) ? ACT_MOVE_TOP : ACT_ALLOCATE;
         MIX_DRAIN:
            act = (roll < 15) ? ACT_ENQUEUE : (roll < 60) ? ACT_REMOVE :
                  (roll < 72) ? ACT_REMOVE_OWNER : (roll < 87) ? ACT_MOVE_TOP : ACT_ALLOCATE;
         default:
            act = (roll < 10) ? ACT_ENQUEUE : (roll < 20) ? ACT_REMOVE :
                  (roll < 30) ? ACT_MOVE_TOP : ACT_ALLOCATE;
      endcase
      // Sprinkle ignored codes into the churn mix as noise.
      if (mix == MIX_CHURN && roll >= 95)
         act = ACT_RESERVED_FIRST + ACTION_W'($urandom_range(0, RESERVED_SPAN));
      // New entries mostly take fresh keys so the stack can grow.
      if (act == ACT_ENQUEUE && $urandom_range(0, 99) < 80) begin
         owner  = KEY_W'($urandom_range(0, KEY_MAX));
         window = KEY_W'($urandom_range(0, KEY_MAX));
      end else begin
         pick_key(owner, window);
      end
      return make_request(act, owner, window, TASK_W'($urandom_range(0, TASK_MAX)));
   endfunction

   // Keep only a short backlog, so keys are picked from a fresh shadow stack.
   task automatic offer_request(input req_type r);
      while (queued_actions.size() >= QUEUE_AHEAD)
         @(posedge clock);
      queued_actions.push_back(r);
      issued_count++;
   endtask

   task automatic wait_all_answered();
      while (answered_count < issued_count)
         @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence: directed corner cases, then random mixes
   // ---------------------------------------------------------------------
   initial begin
      int      n;
      mix_type mix;
      while (reset)
         @(posedge clock);

      // Empty-stack corners: fresh id, move and remove miss, remove-all is ok.
      offer_request(make_request(ACT_ALLOCATE,     3'd0, 3'd0, 6'd0));
      offer_request(make_request(ACT_MOVE_TOP,     3'd0, 3'd0, 6'd0));
      offer_request(make_request(ACT_REMOVE,       3'd7, 3'd7, 6'd63));
      offer_request(make_request(ACT_REMOVE_OWNER, 3'd0, 3'd0, 6'd0));
      // Build a small stack, hit a duplicate key.
      offer_request(make_request(ACT_ENQUEUE,      3'd0, 3'd0, 6'd0));
      offer_request(make_request(ACT_ENQUEUE,      3'd7, 3'd7, 6'd63));
      offer_request(make_request(ACT_ENQUEUE,      3'd0, 3'd0, 6'd21));
      offer_request(make_request(ACT_ENQUEUE,      3'd7, 3'd0, 6'd42));
      // Move from the middle, move the top again, move an absent key.
      offer_request(make_request(ACT_MOVE_TOP,     3'd7, 3'd7, 6'd0));
      offer_request(make_request(ACT_MOVE_TOP,     3'd7, 3'd7, 6'd63));
      offer_request(make_request(ACT_MOVE_TOP,     3'd3, 3'd5, 6'd0));
      // Remove the oldest entry, then the same key again.
      offer_request(make_request(ACT_REMOVE,       3'd0, 3'd0, 6'd0));
      offer_request(make_request(ACT_REMOVE,       3'd0, 3'd0, 6'd63));
      offer_request(make_request(ACT_REMOVE_OWNER, 3'd7, 3'd0, 6'd0));
      // Ignored codes with extreme fields.
      offer_request(make_request(ACT_RESERVED_FIRST,        3'd7, 3'd7, 6'd63));
      offer_request(make_request(ACT_RESERVED_FIRST + 3'd1, 3'd0, 3'd0, 6'd0));
      offer_request(make_request(ACT_RESERVED_FIRST + 3'd2, 3'd7, 3'd0, 6'd63));
      offer_request(make_request(ACT_ALLOCATE,     3'd7, 3'd7, 6'd63));
      offer_request(make_request(ACT_ENQUEUE,      3'd0, 3'd7, 6'd0));
      offer_request(make_request(ACT_REMOVE_OWNER, 3'd5, 3'd2, 6'd0));

      for (n = 0; n < RANDOM_ACTIONS; n++) begin
         // Hold the sender until every reply is back, once, mid-run.
         if (n == PAUSE_AT)
            wait_all_answered();
         // Drop all random idling on both sides for one stretch.
         calm_stretch = (n >= 100 && n < 170);
         mix = mix_type'((n / 64) % 4);
         offer_request(random_action(mix));
      end

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d expected replies never arrived", $time, expected_replies.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("window_stack_order_table_tb passed");
      end else begin
         $display("window_stack_order_table_tb failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: present queued transactions, predict each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(predict_action(req_data));
            accepted_count++;
         end
         // Hold valid and payload while the block stalls; otherwise advance or idle.
         if (!req_valid || req_ready) begin
            if (queued_actions.size() != 0 &&
                (calm_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_data  <= queued_actions.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each reply with the oldest prediction, throttle ready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answered_count++;
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with nothing expected, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status",      8'(want.status),      8'(rsp_data.status));
               check_field("task_out",    8'(want.task_out),    8'(rsp_data.task_out));
               check_field("entry_count", 8'(want.entry_count), 8'(rsp_data.entry_count));
            end
         end
         // Once, refuse replies for a long stretch so the block backs up its input.
         if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("window_stack_order_table_tb failed");
         $finish;
      end
   end

endmodule

// ===== files.f =====
design/wsot_pkg.sv
design/wsot_cell.sv
design/wsot_id_alloc.sv
design/window_stack_order_table.sv
design/wsot_checker.sv
dv/window_stack_order_table_tb.sv
